@@ rtl/hksum_pkg.sv @@
package hksum_pkg;

  localparam int INDEX_W = 6;
  localparam int HIGH_W  = 32;
  localparam int LOW_W   = 24;
  localparam int KSV_W   = 40;
  localparam int KM_W    = 56;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

endpackage

@@ rtl/hksum_if.sv @@
interface hksum_req_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [hksum_pkg::INDEX_W-1:0]     key_index;
  logic [hksum_pkg::HIGH_W-1:0]      key_high;
  logic [hksum_pkg::LOW_W-1:0]       key_low;
  logic [hksum_pkg::KSV_W-1:0]       ksv;

  modport source(output valid, output mode, output key_index, output key_high,
                 output key_low, output ksv, input ready);
  modport sink(input valid, input mode, input key_index, input key_high,
               input key_low, input ksv, output ready);
endinterface

interface hksum_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [hksum_pkg::KM_W-1:0]    km;

  modport source(output valid, output km, input ready);
  modport sink(input valid, input km, output ready);
endinterface

@@ rtl/hksum_ram.sv @@
module hksum_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/hdcp_km_key_sum_unit.sv @@
// Km key-sum unit. A load item (mode 0) writes one device key, split into
// its upper 32 and lower 24 bits, into key slot key_index and
// gives no result; slots at or above NUM_KEYS are ignored. A compute item
// (mode 1) sums, modulo 2^KEY_WIDTH, every stored key whose slot bit is set
// in ksv and gives one km item. The sum walks the key RAM one slot per cycle
// through its single read port into one shared adder. After it takes a
// compute item the block holds ready low through its RUN, DRAIN and FINISH
// states, and takes no new item until the sum has been written to km.
// A finished result sits in an output register, and the block takes new
// items while it waits there; a later compute item that finishes before
// that result is taken holds the block until it is. Keys must be loaded
// before a compute item selects them.
module hdcp_km_key_sum_unit #(
  parameter int NUM_KEYS  = 40,
  parameter int KEY_WIDTH = 56
) (
  input  logic        clk,
  input  logic        rst,
  hksum_req_if.sink   req,
  hksum_rsp_if.source rsp
);

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  logic [AW-1:0]                cnt;
  logic [hksum_pkg::KSV_W-1:0]  ksv_sh;
  logic                         pend_vld;
  logic                         pend_sel;
  logic                         pend_last;
  logic [KEY_WIDTH-1:0]         acc;
  logic                         out_vld;
  logic [hksum_pkg::KM_W-1:0]   km;

  logic                         accept;
  logic                         load_we;
  logic [KEY_WIDTH-1:0]         load_key;
  logic [AW-1:0]                load_addr;
  logic                         rd_en;
  logic [KEY_WIDTH-1:0]         rd_data;
  logic                         issue_last;
  logic                         out_free;
  logic [63:0]                  acc_ext;
  logic [hksum_pkg::HIGH_W+hksum_pkg::LOW_W-1:0] key_raw;

  assign accept     = req.valid && req.ready;
  assign key_raw    = {req.key_high, req.key_low};
  assign load_key   = KEY_WIDTH'(64'(key_raw));
  assign load_addr  = AW'(req.key_index);
  assign load_we    = accept && (req.mode == hksum_pkg::MODE_LOAD)
                      && ({1'b0, req.key_index} < 7'(NUM_KEYS));
  assign rd_en      = (state == ST_RUN);
  assign issue_last = (cnt == AW'(NUM_KEYS - 1));
  assign out_free   = !out_vld || rsp.ready;
  assign acc_ext    = 64'(acc);

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_vld;
  assign rsp.km    = km;

  hksum_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(NUM_KEYS)
  ) u_key_ram (
    .clk  (clk),
    .we   (load_we),
    .waddr(load_addr),
    .wdata(load_key),
    .re   (rd_en),
    .raddr(cnt),
    .rdata(rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (req.mode == hksum_pkg::MODE_COMPUTE)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pend_vld && pend_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      pend_vld  <= 1'b0;
      pend_last <= 1'b0;
      out_vld   <= 1'b0;
    end else begin
      state     <= state_next;
      pend_vld  <= rd_en;
      pend_last <= rd_en && issue_last;
      if (rd_en) begin
        cnt <= issue_last ? '0 : cnt + AW'(1);
      end
      if (state == ST_FINISH && out_free) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      ksv_sh <= req.ksv;
      acc    <= '0;
    end else begin
      if (rd_en) begin
        ksv_sh <= ksv_sh >> 1;
      end
      if (pend_vld && pend_sel) begin
        acc <= acc + rd_data;
      end
    end
    if (rd_en) begin
      pend_sel <= ksv_sh[0];
    end
    if (state == ST_FINISH && out_free) begin
      km <= acc_ext[hksum_pkg::KM_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_vld) |-> $past(state) == ST_FINISH)
    else $error("result raised outside the finish step");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (cnt == '0) && !pend_vld)
    else $error("sequencer idle with a read still in flight");

  a_last_has_data: assert property (@(posedge clk) disable iff (rst)
    pend_last |-> pend_vld && (state == ST_DRAIN))
    else $error("last key flag without its read data");

  a_run_from_compute: assert property (@(posedge clk) disable iff (rst)
    (accept && req.mode == hksum_pkg::MODE_COMPUTE) |=> (state == ST_RUN) && (cnt == '0))
    else $error("compute item did not start the key walk");
`endif

endmodule
